>>> rtl/tcrh_pkg.sv
// Shared types and constants for the range and height block.
// No dependencies; every other file in rtl/ imports this package.
package tcrh_pkg;

  localparam int unsigned DIV_STEPS = 104;  // 64-bit numerator with 40 fraction bits appended
  localparam int unsigned MUL_STEPS = 48;

  localparam logic [31:0] ANGLE_MAX = 32'd3006477107;  // floor(1.4 * 2^31)
  localparam logic [63:0] ONE_Q40 = 64'h0000_0100_0000_0000;
  localparam logic [47:0] LEN_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [30:0] HEIGHT_RESET = 31'd25165824;
  localparam logic [20:0] TOL_RESET = 21'd110;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic CFG_HEIGHT = 1'b0;
  localparam logic CFG_TOL = 1'b1;

  typedef enum logic [1:0] {
    DIV_TERM,
    DIV_LAST,
    DIV_DIST
  } div_sel_t;

  typedef struct packed {
    logic [31:0] alpha;
    logic [31:0] beta;
    logic        beta_given;
  } tcrh_in_t;

  typedef struct packed {
    logic [47:0] distance;
    logic [47:0] object_height;
    logic        height_valid;
    logic [1:0]  status;
  } tcrh_out_t;

  typedef struct packed {
    logic     load_in;
    logic     prep;
    logic     sel_beta;
    logic     v_clr;
    logic     div_start;
    div_sel_t div_sel;
    logic     v_load;
    logic     prev_load;
    logic     tan_a_load;
    logic     tan_b_load;
    logic     dist_load;
    logic     mul_start;
    logic     hgt_load;
    logic     out_load;
  } tcrh_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic conv;
    logic inval;
    logic given;
  } tcrh_stat_t;

  function automatic logic angle_ok(input logic [31:0] a);
    return (a != 32'd0) && (a <= ANGLE_MAX);
  endfunction

endpackage

>>> rtl/tcrh_div.sv
// Restoring divider: floor(num * 2^40 / den), one quotient bit per cycle.
// Saturates to all ones when the quotient needs more than 64 bits. Uses tcrh_pkg.
module tcrh_div import tcrh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [63:0] quo,
  output logic        done
);

  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  logic [63:0] rem_r;
  logic [63:0] dvd_r;
  logic [63:0] den_r;
  logic [63:0] q_r;
  logic        ovf_r;

  logic [64:0] rem_sh;
  logic        fits;
  logic [64:0] rem_sub;

  assign rem_sh  = {rem_r, dvd_r[63]};
  assign fits    = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 64'd0;
      dvd_r <= num;
      den_r <= den;
      q_r   <= 64'd0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sub[63:0] : rem_sh[63:0];
      dvd_r <= {dvd_r[62:0], 1'b0};
      q_r   <= {q_r[62:0], fits};
      ovf_r <= ovf_r | q_r[63];
    end
  end

  assign quo  = ovf_r ? {64{1'b1}} : q_r;
  assign done = done_r;

endmodule

>>> rtl/tcrh_dp.sv
// Datapath: config registers, angle prep, fraction operands, divider,
// shift-add multiplier and the result register. Uses tcrh_pkg and tcrh_div.
module tcrh_dp import tcrh_pkg::*; #(
  parameter int unsigned MAX_DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tcrh_cmd_t                            cmd,
  input  logic [$clog2(2 * MAX_DEPTH) - 1:0]   c_i,
  output tcrh_stat_t                           st,
  input  tcrh_in_t                             in_data,
  output tcrh_out_t                            out_data,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [30:0]                          cfg_wdata
);

  logic [30:0] ih_r;
  logic [20:0] tol_r;
  tcrh_in_t    in_r;
  logic [40:0] x40_r;
  logic [41:0] x2_r;
  logic [63:0] v_r;
  logic [63:0] prev_r;
  logic [63:0] tan_a_r;
  logic [63:0] tan_b_r;
  logic [47:0] dist_r;
  logic [47:0] hgt_r;
  logic        sat_r;
  tcrh_out_t   out_r;

  logic [31:0] ang;
  logic [63:0] sq;
  logic [64:0] top_term;
  logic [63:0] div_num;
  logic [63:0] div_den;
  logic [63:0] quo;
  logic        div_done;
  logic [63:0] diff;
  logic        inval;

  logic         mul_busy_r;
  logic         mul_done_r;
  logic [5:0]   mcnt_r;
  logic [47:0]  mplier_r;
  logic [111:0] acc_r;
  logic [47:0]  prod_c;
  logic [48:0]  hsum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ih_r  <= HEIGHT_RESET;
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEIGHT: ih_r  <= cfg_wdata;
        CFG_TOL:    tol_r <= cfg_wdata[20:0];
        default:    ;
      endcase
    end
  end

  assign ang = cmd.sel_beta ? in_r.beta : in_r.alpha;
  assign sq  = ang * ang;
  assign top_term = 65'({c_i, 40'b0});

  always_comb begin
    case (cmd.div_sel)
      DIV_TERM: begin
        div_num = {22'd0, x2_r};
        div_den = (top_term > {1'b0, v_r}) ? 64'(top_term - {1'b0, v_r}) : 64'd1;
      end
      DIV_LAST: begin
        div_num = {23'd0, x40_r};
        div_den = (ONE_Q40 > v_r) ? ONE_Q40 - v_r : 64'd1;
      end
      DIV_DIST: begin
        div_num = {33'd0, ih_r};
        div_den = tan_a_r;
      end
      default: begin
        div_num = 64'd0;
        div_den = 64'd1;
      end
    endcase
  end

  tcrh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .done  (div_done)
  );

  assign diff  = (quo >= prev_r) ? quo - prev_r : prev_r - quo;
  assign inval = !angle_ok(in_r.alpha) || (in_r.beta_given && !angle_ok(in_r.beta));

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r  <= in_data;
      sat_r <= 1'b0;
      hgt_r <= 48'd0;
      dist_r <= 48'd0;
    end
    if (cmd.prep) begin
      x40_r  <= {ang, 9'd0};
      x2_r   <= sq[63:22];
      prev_r <= 64'd0;
    end
    if (cmd.v_clr) v_r <= 64'd0;
    if (cmd.v_load) v_r <= quo;
    if (cmd.prev_load) prev_r <= quo;
    if (cmd.tan_a_load) tan_a_r <= quo;
    if (cmd.tan_b_load) tan_b_r <= quo;
    if (cmd.dist_load) begin
      if (quo[63:48] != 16'd0) begin
        dist_r <= LEN_MAX;
        sat_r  <= 1'b1;
      end else begin
        dist_r <= quo[47:0];
      end
    end
    if (cmd.hgt_load) begin
      if (hsum[48]) begin
        hgt_r <= LEN_MAX;
        sat_r <= 1'b1;
      end else begin
        hgt_r <= hsum[47:0];
      end
    end
    if (cmd.out_load) begin
      if (inval) begin
        out_r <= '{distance: 48'd0, object_height: 48'd0, height_valid: 1'b0,
                   status: ST_RANGE};
      end else begin
        out_r.distance      <= dist_r;
        out_r.object_height <= in_r.beta_given ? hgt_r : 48'd0;
        out_r.height_valid  <= in_r.beta_given;
        out_r.status        <= sat_r ? ST_SAT : ST_OK;
      end
    end
  end

  // distance * tan(beta), MSB of the distance first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_done_r <= 1'b0;
      mcnt_r     <= 6'd0;
    end else begin
      mul_done_r <= 1'b0;
      if (cmd.mul_start) begin
        mul_busy_r <= 1'b1;
        mcnt_r     <= 6'd0;
      end else if (mul_busy_r) begin
        mcnt_r <= mcnt_r + 6'd1;
        if (mcnt_r == 6'(MUL_STEPS - 1)) begin
          mul_busy_r <= 1'b0;
          mul_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      acc_r    <= 112'd0;
      mplier_r <= dist_r;
    end else if (mul_busy_r) begin
      acc_r    <= {acc_r[110:0], 1'b0} + (mplier_r[47] ? {48'd0, tan_b_r} : 112'd0);
      mplier_r <= {mplier_r[46:0], 1'b0};
    end
  end

  // clamp the product to the length range before adding the instrument height
  assign prod_c = (acc_r[111:88] != 24'd0) ? LEN_MAX : acc_r[87:40];
  assign hsum   = {1'b0, prod_c} + {18'd0, ih_r};

  assign st.div_done = div_done;
  assign st.mul_done = mul_done_r;
  assign st.conv     = diff < {43'd0, tol_r};
  assign st.inval    = inval;
  assign st.given    = in_r.beta_given;
  assign out_data    = out_r;

endmodule

>>> rtl/tcrh_ctrl.sv
// Controller: sequences depth search, tangent evaluation, distance and height.
// Drives tcrh_dp through tcrh_cmd_t, reads tcrh_stat_t. Uses tcrh_pkg.
module tcrh_ctrl import tcrh_pkg::*; #(
  parameter int unsigned MAX_DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output tcrh_cmd_t                            cmd,
  output logic [$clog2(2 * MAX_DEPTH) - 1:0]   c_o,
  input  tcrh_stat_t                           st
);

  localparam int unsigned CW = $clog2(2 * MAX_DEPTH);
  localparam int unsigned NW = $clog2(MAX_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_PREP,
    S_EVAL,
    S_TERM,
    S_TWAIT,
    S_LWAIT,
    S_DIST,
    S_DWAIT,
    S_MUL,
    S_MWAIT,
    S_FIN
  } state_t;

  state_t        state_r;
  logic [NW-1:0] n_r;
  logic [CW-1:0] c_r;
  logic          search_r;
  logic          beta_phase_r;
  logic          out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.sel_beta = beta_phase_r;
    cmd.div_sel  = DIV_TERM;
    case (state_r)
      S_IDLE:  cmd.load_in = in_valid;
      S_PREP:  cmd.prep = 1'b1;
      S_EVAL:  cmd.v_clr = 1'b1;
      S_TERM: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = (c_r > CW'(1)) ? DIV_TERM : DIV_LAST;
      end
      S_TWAIT: cmd.v_load = st.div_done;
      S_LWAIT: begin
        cmd.div_sel    = DIV_LAST;
        cmd.prev_load  = st.div_done && search_r;
        cmd.tan_a_load = st.div_done && !search_r && !beta_phase_r;
        cmd.tan_b_load = st.div_done && !search_r && beta_phase_r;
      end
      S_DIST: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DIST;
      end
      S_DWAIT: begin
        cmd.div_sel   = DIV_DIST;
        cmd.dist_load = st.div_done;
      end
      S_MUL:   cmd.mul_start = 1'b1;
      S_MWAIT: cmd.hgt_load = st.mul_done;
      S_FIN:   cmd.out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      n_r          <= NW'(1);
      c_r          <= CW'(1);
      search_r     <= 1'b0;
      beta_phase_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            beta_phase_r <= 1'b0;
            state_r      <= S_CHECK;
          end
        end
        S_CHECK: state_r <= st.inval ? S_FIN : S_PREP;
        S_PREP: begin
          n_r      <= NW'(1);
          search_r <= 1'b1;
          state_r  <= S_EVAL;
        end
        S_EVAL: begin
          c_r     <= CW'({n_r, 1'b0} - 1);
          state_r <= S_TERM;
        end
        S_TERM: state_r <= (c_r > CW'(1)) ? S_TWAIT : S_LWAIT;
        S_TWAIT: begin
          if (st.div_done) begin
            c_r     <= c_r - CW'(2);
            state_r <= S_TERM;
          end
        end
        S_LWAIT: begin
          if (st.div_done) begin
            if (search_r) begin
              // the depth after the converged one is the one used
              n_r <= n_r + NW'(1);
              if (st.conv || n_r == NW'(MAX_DEPTH - 1)) search_r <= 1'b0;
              state_r <= S_EVAL;
            end else if (!beta_phase_r && st.given) begin
              beta_phase_r <= 1'b1;
              state_r      <= S_PREP;
            end else begin
              state_r <= S_DIST;
            end
          end
        end
        S_DIST:  state_r <= S_DWAIT;
        S_DWAIT: if (st.div_done) state_r <= st.given ? S_MUL : S_FIN;
        S_MUL:   state_r <= S_MWAIT;
        S_MWAIT: if (st.mul_done) state_r <= S_FIN;
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign c_o       = c_r;

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_CHECK)
    else $error("accepted item did not start range check");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while held");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> (state_r == S_TWAIT || state_r == S_LWAIT || state_r == S_DWAIT))
    else $error("divider finished outside a wait state");

  a_depth_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(MAX_DEPTH))
    else $error("fraction depth above cap");

endmodule

>>> rtl/tangent_cfrac_range_height.sv
// Channel  Ports                           Role
// in       in_valid, in_stall, in_data     alpha, beta, beta_given
// out      out_valid, out_stall, out_data  distance, object_height, height_valid, status
// cfg      cfg_we, cfg_index, cfg_wdata    0 instrument_height, 1 tolerance
//
// One item at a time. Every fraction term is one pass of the shared bit-serial
// divider plus control states, so an angle converging at depth D costs
// D*(D+1)/2 + D + 1 divider passes. The distance adds one more division;
// a height repeats the search for beta and adds a shift-add multiply.
// Out-of-range items skip straight to the result. Synchronous active-low reset restores
// register defaults; a stalled result holds while the next item is accepted.
// Uses tcrh_pkg, tcrh_ctrl, tcrh_dp.
module tangent_cfrac_range_height import tcrh_pkg::*; #(
  parameter int unsigned MAX_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  tcrh_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output tcrh_out_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_wdata
);

  tcrh_cmd_t                          cmd;
  tcrh_stat_t                         st;
  logic [$clog2(2 * MAX_DEPTH) - 1:0] c_val;

  tcrh_ctrl #(.MAX_DEPTH(MAX_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .c_o       (c_val),
    .st        (st)
  );

  tcrh_dp #(.MAX_DEPTH(MAX_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .c_i       (c_val),
    .st        (st),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule
